/* rtl/core/fcsol_pkg.sv */
package fcsol_pkg;

    // list geometry
    localparam int ENTRIES     = 1024;
    localparam int KEY_WIDTH   = 32;
    localparam int COUNT_WIDTH = 16;
    localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_W      = $clog2(ENTRIES + 1);

    // port field widths
    localparam int KEY_IN_W    = 32;
    localparam int STATUS_W    = 2;
    localparam int POS_W       = 10;
    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 16;
    localparam int OUT_PAD_W   = TDATA_OUT_W - POS_W - STATUS_W;

    // first-set search tree: groups of cells, then one level over the groups
    localparam int GRP    = 64;
    localparam int GRP_W  = 6;
    localparam int NGRP   = (ENTRIES + GRP - 1) / GRP;
    localparam int GSEL_W = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int NPAD   = NGRP * GRP;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [FILL_W-1:0]      FILL_FULL = FILL_W'(ENTRIES);

    // request kinds
    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_ACCESS = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_APPENDED = 2'd0,
        ST_HIT      = 2'd1,
        ST_MISS     = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic                   less_phase;
        logic                   move_en;
        logic [KEY_WIDTH-1:0]   key;
        logic [COUNT_WIDTH-1:0] cnt;
        logic [IDX_W-1:0]       dst;
        logic [IDX_W-1:0]       hi;
        logic [FILL_W-1:0]      fill;
    } bcast_t;

    // answer of the first-set search
    typedef struct packed {
        logic                   found;
        logic [IDX_W-1:0]       idx;
        logic [COUNT_WIDTH-1:0] cnt;
    } find_t;

    // list index to the low bits of the position field
    function automatic logic [POS_W-1:0] idx_to_pos(input logic [IDX_W-1:0] idx);
        logic [IDX_W+POS_W-1:0] wide;
        wide = (IDX_W + POS_W)'(idx);
        return wide[POS_W-1:0];
    endfunction

endpackage

/* rtl/core/frequency_count_self_organizing_list_core.sv */
// Frequency-count self-organizing list.
// Input channel s_*: one request per handshake. s_tuser[0] is the kind
// (0 append key at tail, 1 access key), s_tdata[31:0] the signed key.
// Result channel m_*: exactly one result per request, in request order.
// m_tdata[1:0] status (appended, hit, miss, full), m_tdata[11:2] position.
// The list lives in a chain of cells; a hit entry is rewritten at its new
// place while the cells between shift one step toward the tail in the same cycle.
// Each lookup pass is a cell flag register plus two registered levels of
// the first-set search tree; a hit needs two passes (find the key, then
// find the first lower count), a hit on a saturated count only the first.
// One request is in flight at a time; s_tready returns when the result is
// loaded into the output register, so a new request is taken while that
// result still waits for m_tready. If the receiver stalls with a result
// pending, the next finished result waits inside until the register frees.
// Reset (aresetn low, synchronous) empties the list and drops any result;
// the stored keys and counts are not cleared, only the fill level.
module frequency_count_self_organizing_list_core import fcsol_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // [31:0] key
    input  logic [0:0]             s_tuser,   // [0] kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata    // [1:0] status, [11:2] position
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_EVAL,
        S_MOVE,
        S_RESP
    } state_t;

    localparam logic [1:0] FIND_LAST = 2'd2;

    state_t                   state_reg, state_next;
    logic [1:0]               wait_reg, wait_next;
    logic                     less_reg, less_next;
    logic [KEY_WIDTH-1:0]     key_reg, key_next;
    logic [COUNT_WIDTH-1:0]   newc_reg, newc_next;
    logic [IDX_W-1:0]         d_reg, d_next;
    logic [IDX_W-1:0]         h_reg, h_next;
    logic [FILL_W-1:0]        fill_reg, fill_next;
    status_t                  status_reg, status_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [TDATA_OUT_W-1:0]   m_tdata_reg, m_tdata_next;

    bcast_t                             bcast;
    find_t                              find;
    logic [ENTRIES-1:0][KEY_WIDTH-1:0]  cell_key;
    logic [NPAD-1:0][COUNT_WIDTH-1:0]   cell_cnt;
    logic [NPAD-1:0]                    cell_flag;
    logic [POS_W-1:0]                   res_pos;

    // broadcast to the chain
    always_comb begin
        bcast.less_phase = less_reg;
        bcast.move_en    = state_reg == S_MOVE;
        bcast.key        = key_reg;
        bcast.cnt        = newc_reg;
        bcast.dst        = d_reg;
        bcast.hi         = h_reg;
        bcast.fill       = fill_reg;
    end

    // chain of cells, each taking its neighbor toward the head
    for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
        logic [KEY_WIDTH-1:0]   prev_key;
        logic [COUNT_WIDTH-1:0] prev_cnt;
        if (j == 0) begin : g_head
            assign prev_key = '0;
            assign prev_cnt = '0;
        end else begin : g_body
            assign prev_key = cell_key[j-1];
            assign prev_cnt = cell_cnt[j-1];
        end
        fcsol_cell u_cell (
            .aclk     (aclk),
            .cell_idx (IDX_W'(j)),
            .bcast    (bcast),
            .prev_key (prev_key),
            .prev_cnt (prev_cnt),
            .key_out  (cell_key[j]),
            .cnt_out  (cell_cnt[j]),
            .flag_out (cell_flag[j])
        );
    end

    // unused tree leaves
    for (genvar j = ENTRIES; j < NPAD; j++) begin : g_pad
        assign cell_flag[j] = 1'b0;
        assign cell_cnt[j]  = '0;
    end

    fcsol_find u_find (
        .aclk   (aclk),
        .flags  (cell_flag),
        .cnts   (cell_cnt),
        .result (find)
    );

    // result fields
    always_comb begin
        if (status_reg == ST_APPENDED || status_reg == ST_HIT) begin
            res_pos = idx_to_pos(d_reg);
        end else begin
            res_pos = '0;
        end
    end

    // request sequencer
    always_comb begin
        state_next    = state_reg;
        wait_next     = wait_reg;
        less_next     = less_reg;
        key_next      = key_reg;
        newc_next     = newc_reg;
        d_next        = d_reg;
        h_next        = h_reg;
        fill_next     = fill_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    key_next = s_tdata[KEY_WIDTH-1:0];
                    if (s_tuser[0] == KIND_ACCESS) begin
                        less_next  = 1'b0;
                        wait_next  = '0;
                        state_next = S_FIND;
                    end else if (fill_reg == FILL_FULL) begin
                        status_next = ST_FULL;
                        state_next  = S_RESP;
                    end else begin
                        d_next      = fill_reg[IDX_W-1:0];
                        h_next      = fill_reg[IDX_W-1:0];
                        newc_next   = '0;
                        fill_next   = fill_reg + 1'b1;
                        status_next = ST_APPENDED;
                        state_next  = S_MOVE;
                    end
                end
            end
            S_FIND: begin
                wait_next = wait_reg + 1'b1;
                if (wait_reg == FIND_LAST) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (less_reg) begin
                    d_next     = find.idx;
                    state_next = S_MOVE;
                end else if (!find.found) begin
                    status_next = ST_MISS;
                    state_next  = S_RESP;
                end else begin
                    h_next      = find.idx;
                    status_next = ST_HIT;
                    if (find.cnt == COUNT_MAX) begin
                        // saturated count never passes anything
                        d_next     = find.idx;
                        newc_next  = find.cnt;
                        state_next = S_MOVE;
                    end else begin
                        newc_next  = find.cnt + 1'b1;
                        less_next  = 1'b1;
                        wait_next  = '0;
                        state_next = S_FIND;
                    end
                end
            end
            S_MOVE: begin
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {OUT_PAD_W'(0), res_pos, status_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            wait_reg     <= '0;
            less_reg     <= 1'b0;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wait_reg     <= wait_next;
            less_reg     <= less_next;
            fill_reg     <= fill_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        key_reg     <= key_next;
        newc_reg    <= newc_next;
        d_reg       <= d_next;
        h_reg       <= h_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* rtl/core/fcsol_cell.sv */
module fcsol_cell import fcsol_pkg::*; (
    input  logic                   aclk,
    input  logic [IDX_W-1:0]       cell_idx,
    input  bcast_t                 bcast,
    input  logic [KEY_WIDTH-1:0]   prev_key,
    input  logic [COUNT_WIDTH-1:0] prev_cnt,
    output logic [KEY_WIDTH-1:0]   key_out,
    output logic [COUNT_WIDTH-1:0] cnt_out,
    output logic                   flag_out
);

    logic [KEY_WIDTH-1:0]   key_reg, key_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                   flag_reg, flag_next;
    logic                   in_list;
    logic                   is_dst;
    logic                   in_run;

    // position tests against the broadcast
    always_comb begin
        in_list = FILL_W'(cell_idx) < bcast.fill;
        is_dst  = cell_idx == bcast.dst;
        in_run  = (cell_idx > bcast.dst) && (cell_idx <= bcast.hi);
    end

    // load the moved entry, or take the neighbor's entry to open the gap
    always_comb begin
        key_next = key_reg;
        cnt_next = cnt_reg;
        if (bcast.move_en) begin
            if (is_dst) begin
                key_next = bcast.key;
                cnt_next = bcast.cnt;
            end else if (in_run) begin
                key_next = prev_key;
                cnt_next = prev_cnt;
            end
        end
    end

    // key match, or count below the new count
    always_comb begin
        if (bcast.less_phase) begin
            flag_next = in_list && (cnt_reg < bcast.cnt);
        end else begin
            flag_next = in_list && (key_reg == bcast.key);
        end
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        cnt_reg  <= cnt_next;
        flag_reg <= flag_next;
    end

    assign key_out  = key_reg;
    assign cnt_out  = cnt_reg;
    assign flag_out = flag_reg;

endmodule

/* rtl/core/fcsol_find.sv */
module fcsol_find import fcsol_pkg::*; (
    input  logic                              aclk,
    input  logic [NPAD-1:0]                   flags,
    input  logic [NPAD-1:0][COUNT_WIDTH-1:0]  cnts,
    output find_t                             result
);

    logic [NGRP-1:0]                   grp_any_reg, grp_any_next;
    logic [NGRP-1:0][GRP_W-1:0]        grp_off_reg, grp_off_next;
    logic [NGRP-1:0][COUNT_WIDTH-1:0]  grp_cnt_reg, grp_cnt_next;
    find_t                             res_reg, res_next;
    logic [GSEL_W+GRP_W-1:0]           idx_full;

    // first level: lowest flagged cell inside each group
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_any_next[g] = 1'b0;
            grp_off_next[g] = '0;
            grp_cnt_next[g] = '0;
            for (int i = GRP - 1; i >= 0; i--) begin
                if (flags[g*GRP+i]) begin
                    grp_any_next[g] = 1'b1;
                    grp_off_next[g] = GRP_W'(i);
                    grp_cnt_next[g] = cnts[g*GRP+i];
                end
            end
        end
    end

    // second level: lowest group with a flagged cell
    always_comb begin
        idx_full = '0;
        res_next = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (grp_any_reg[g]) begin
                idx_full       = {GSEL_W'(g), grp_off_reg[g]};
                res_next.found = 1'b1;
                res_next.cnt   = grp_cnt_reg[g];
            end
        end
        res_next.idx = idx_full[IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        grp_any_reg <= grp_any_next;
        grp_off_reg <= grp_off_next;
        grp_cnt_reg <= grp_cnt_next;
        res_reg     <= res_next;
    end

    assign result = res_reg;

endmodule

/* rtl/core/fcsol_checker.sv */
module fcsol_checker import fcsol_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [TDATA_OUT_W-1:0] m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // reset drops any pending result
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // one request in flight: no accept in the cycle after an accept
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // miss and full carry position zero
    a_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[STATUS_W-1:0] == STATUS_W'(ST_MISS) ||
                     m_tdata[STATUS_W-1:0] == STATUS_W'(ST_FULL))
        |-> m_tdata[STATUS_W+POS_W-1:STATUS_W] == '0)
        else $error("nonzero position on miss or full");

endmodule

bind frequency_count_self_organizing_list_core fcsol_checker u_fcsol_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
